### hdl/lu8_pkg.sv
// Shared types, constants and lead-byte classification for the lenient UTF-8 decoder.
`default_nettype none
package lu8_pkg;

	localparam int unsigned RES_SLOTS = 4;

	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  byte_count;
		logic        text_done;
	} result_t;

	typedef struct packed {
		logic [7:0] lead;
		logic [2:0] exp_len;
		logic [1:0] collected;
	} seq_state_t;

	typedef struct packed {
		result_t [RES_SLOTS-1:0] results;
		logic [2:0]              num_results;
		seq_state_t              next_seq;
		logic                    held_we;
		logic                    held_idx;
	} step_out_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_ONE;
		if (b >= LEAD2_LO && b <= LEAD2_HI) len = LEN_TWO;
		if (b >= LEAD3_LO && b <= LEAD3_HI) len = LEN_THREE;
		if (b >= LEAD4_LO && b <= LEAD4_HI) len = LEN_FOUR;
		return len;
	endfunction

endpackage
`default_nettype wire

### hdl/lu8_step.sv
// Combinational decode of one byte against the open sequence: results and next state.
`default_nettype none
module lu8_step import lu8_pkg::*; (
	input  wire logic [7:0] text_byte,
	input  wire logic       final_byte,
	input  wire seq_state_t seq,
	input  wire logic [7:0] held0,
	input  wire logic [7:0] held1,
	output step_out_t       step
);

	logic [2:0]  new_len;
	logic        is_cont;
	logic        complete;
	logic [20:0] seq_cp;

	assign new_len  = lead_length(text_byte);
	assign is_cont  = (text_byte & CONT_MASK) == CONT_TAG;
	assign complete = ({1'b0, seq.collected} + 3'd2) >= seq.exp_len;

	always_comb begin
		unique case (seq.exp_len)
			LEN_TWO:   seq_cp = {10'd0, seq.lead[4:0], text_byte[5:0]};
			LEN_THREE: seq_cp = {5'd0, seq.lead[3:0], held0[5:0], text_byte[5:0]};
			default:   seq_cp = {seq.lead[2:0], held0[5:0], held1[5:0], text_byte[5:0]};
		endcase
	end

	always_comb begin
		logic [1:0] slot;
		slot = 2'd0;
		step = '0;
		step.next_seq = seq;
		step.held_idx = seq.collected[0];
		if (seq.exp_len != LEN_NONE && is_cont && complete) begin
			step.results[0] = '{code_point: seq_cp, byte_count: seq.exp_len,
				text_done: final_byte};
			step.num_results = 3'd1;
			step.next_seq.exp_len = LEN_NONE;
			step.next_seq.collected = 2'd0;
		end else if (seq.exp_len != LEN_NONE && is_cont && !final_byte) begin
			step.held_we = 1'b1;
			step.next_seq.collected = seq.collected + 2'd1;
		end else begin
			// flush the broken sequence byte by byte, then retry this byte as a lead
			if (seq.exp_len != LEN_NONE) begin
				step.results[0] = '{code_point: {13'd0, seq.lead}, byte_count: LEN_ONE,
					text_done: 1'b0};
				if (seq.collected != 2'd0)
					step.results[1] = '{code_point: {13'd0, held0}, byte_count: LEN_ONE,
						text_done: 1'b0};
				if (seq.collected == 2'd2)
					step.results[2] = '{code_point: {13'd0, held1}, byte_count: LEN_ONE,
						text_done: 1'b0};
				slot = seq.collected + 2'd1;
			end
			step.next_seq.exp_len = LEN_NONE;
			step.next_seq.collected = 2'd0;
			if (new_len == LEN_ONE || final_byte) begin
				step.results[slot] = '{code_point: {13'd0, text_byte}, byte_count: LEN_ONE,
					text_done: final_byte};
				step.num_results = {1'b0, slot} + 3'd1;
			end else begin
				step.next_seq.lead = text_byte;
				step.next_seq.exp_len = new_len;
				step.num_results = {1'b0, slot};
			end
		end
	end

endmodule
`default_nettype wire

### hdl/lenient_utf8_decoder_top.sv
// Lenient UTF-8 decoder: top level with input register, sequence state and result queue.
//
// Input channel (in_valid/in_stall, text_byte, final_byte) takes one byte per transfer;
// output channel (out_valid/out_stall, code_point, byte_count, text_done) gives one code
// point per transfer. A byte is held in the input register, decoded there, and its
// results are registered into a four-entry result queue, from whose head the first
// result can then transfer out. With at most one result per byte and no output stall
// the block takes one byte every cycle. A broken sequence gives up to four results for
// one byte; the queue drains one per cycle while the output is not stalled, so such a
// byte holds the input register (and stalls the input) until the queue has room for all
// of them. A stalled output keeps the head result steady while the queue fills; bytes
// keep flowing until it has no room left.
// Reset empties the input register and the queue and closes any open sequence;
// no clearing pass is needed.
`default_nettype none
module lenient_utf8_decoder_top import lu8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [20:0]      code_point,
	output logic [2:0]       byte_count,
	output logic             text_done
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	seq_state_t seq_q;
	logic [7:0] held_q [2];

	result_t    queue_q [RES_SLOTS];
	result_t    queue_nxt [RES_SLOTS];
	logic [2:0] count_q;
	logic [2:0] count_nxt;

	step_out_t  step;
	logic       pop;
	logic       fire;
	logic       in_take;
	logic [2:0] base;

	lu8_step u_step (
		.text_byte  (byte_s1),
		.final_byte (final_s1),
		.seq        (seq_q),
		.held0      (held_q[0]),
		.held1      (held_q[1]),
		.step       (step)
	);

	assign out_valid  = count_q != 3'd0;
	assign code_point = queue_q[0].code_point;
	assign byte_count = queue_q[0].byte_count;
	assign text_done  = queue_q[0].text_done;

	assign pop     = out_valid && !out_stall;
	assign base    = count_q - {2'd0, pop};
	// fire when the queue, after this cycle's pop, has room for every result
	assign fire    = valid_s1 &&
		(({1'b0, base} + {1'b0, step.num_results}) <= 4'(RES_SLOTS));
	assign in_stall = valid_s1 && !fire;
	assign in_take = in_valid && !in_stall;

	always_comb begin
		logic [2:0] rel;
		for (int k = 0; k < RES_SLOTS; k++) begin
			if (pop && k < RES_SLOTS - 1)
				queue_nxt[k] = queue_q[k + 1];
			else
				queue_nxt[k] = queue_q[k];
			rel = 3'(k) - base;
			if (fire && 3'(k) >= base && rel < step.num_results)
				queue_nxt[k] = step.results[rel[1:0]];
		end
		count_nxt = base + (fire ? step.num_results : 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			seq_q    <= '0;
			count_q  <= 3'd0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				seq_q <= step.next_seq;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
		if (fire && step.held_we)
			held_q[step.held_idx] <= byte_s1;
		for (int k = 0; k < RES_SLOTS; k++)
			queue_q[k] <= queue_nxt[k];
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(RES_SLOTS))
		else $error("result queue over capacity");

	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q.exp_len != LEN_ONE && seq_q.exp_len <= LEN_FOUR)
		else $error("open sequence has illegal length");

	a_collected: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q.exp_len != LEN_NONE || seq_q.collected == 2'd0) &&
		(seq_q.collected <= 2'd2))
		else $error("held byte count out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a stalled byte");

	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count != 3'd0 && byte_count <= LEN_FOUR)
		else $error("result byte count out of range");

endmodule
`default_nettype wire
